### rtl/bchse_pkg.sv
// bchse_pkg: shared types, generator tables and helpers of the serial BCH encoder
package bchse_pkg;

    // generator choice, encoding follows the code_select register
    typedef enum logic [1:0] {
        CODE_N192 = 2'd0,
        CODE_N160 = 2'd1,
        CODE_N128 = 2'd2,
        CODE_S168 = 2'd3
    } code_sel_t;

    localparam int MAX_DEG      = 192;
    localparam int REM_BITS_DEF = 192;
    localparam int CNT_W        = 8;
    localparam int NUM_CODES    = 4;
    localparam int GRP_LEN      = 16;
    localparam int GRP_W        = 4;
    localparam int NUM_GRP      = MAX_DEG / GRP_LEN;
    localparam int TDATA_W      = 8;
    localparam int S_TUSER_W    = 2;

    // generator coefficients, index j holds the coefficient of x^j
    localparam logic [0:192] GEN_192 = {
        32'b11100111101010100100000001100110,
        32'b11101111101000011110001011000000,
        32'b10010001000100001010110000111011,
        32'b00011011001101001111001100001010,
        32'b00111000100010100011101000100001,
        32'b11000001011100000110010001110010,
        1'b1};

    localparam logic [0:160] GEN_160 = {
        32'b10001001101001101101110100011101,
        32'b10000000110001001000101111110111,
        32'b11000000111010100001111001010110,
        32'b11111000110011000101010000111111,
        32'b10110111001100001010100000000110,
        1'b1};

    localparam logic [0:128] GEN_128 = {
        32'b11010100011001101001111100100000,
        32'b10101110101101100011111110011000,
        32'b10111101111010011110010010001110,
        32'b11111010101001001110000000111000,
        1'b1};

    localparam logic [0:168] GEN_168 = {
        32'b10100101101000001001100010001011,
        32'b11101011111001111111000101001010,
        32'b10010110000010011100010111000100,
        32'b10110011010001100100110110010110,
        32'b00011001010101111101101101000110,
        8'b00000010,
        1'b1};

    // per-cycle control handed to every remainder cell
    typedef struct packed {
        logic      shift;
        logic      clear;
        logic      fb;
        code_sel_t sel;
    } cell_ctl_t;

    // parity length of a code
    function automatic logic [CNT_W-1:0] code_deg(code_sel_t code);
        logic [CNT_W-1:0] deg;
        case (code)
            CODE_N192: deg = CNT_W'(192);
            CODE_N160: deg = CNT_W'(160);
            CODE_N128: deg = CNT_W'(128);
            CODE_S168: deg = CNT_W'(168);
            default:   deg = CNT_W'(192);
        endcase
        return deg;
    endfunction

    // coefficient of x^j for each code, bit position is the code value
    function automatic logic [NUM_CODES-1:0] cell_coef(int j);
        logic [NUM_CODES-1:0] c;
        c = '0;
        if (j <= 192) c[CODE_N192] = GEN_192[j];
        if (j <= 160) c[CODE_N160] = GEN_160[j];
        if (j <= 128) c[CODE_N128] = GEN_128[j];
        if (j <= 168) c[CODE_S168] = GEN_168[j];
        return c;
    endfunction

    // cell j takes part in the division when j is below the parity length
    function automatic logic [NUM_CODES-1:0] cell_active(int j);
        logic [NUM_CODES-1:0] a;
        a = '0;
        a[CODE_N192] = (j < 192);
        a[CODE_N160] = (j < 160);
        a[CODE_N128] = (j < 128);
        a[CODE_S168] = (j < 168);
        return a;
    endfunction

endpackage

### rtl/bchse_cell.sv
// bchse_cell: one remainder bit of the premultiplied division register
module bchse_cell
    import bchse_pkg::*;
#(
    parameter logic [NUM_CODES-1:0] COEF   = '0,
    parameter logic [NUM_CODES-1:0] ACTIVE = '0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  logic      prev_bit,
    output logic      rem_bit
);

    logic rem_reg;
    logic rem_next;
    logic prev_eff;

    // start of a codeword wipes the neighbor too before the shift
    assign prev_eff = ctl.clear ? 1'b0 : prev_bit;

    // next remainder bit
    always_comb begin
        rem_next = ctl.clear ? 1'b0 : rem_reg;
        if (ctl.shift && ACTIVE[ctl.sel]) begin
            rem_next = prev_eff ^ (ctl.fb & COEF[ctl.sel]);
        end
    end

    // cell register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 1'b0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    assign rem_bit = rem_reg;

endmodule

### rtl/bch_serial_encoder.sv
// bch_serial_encoder: bit-serial systematic BCH encoder built from a chain of remainder cells
//
//  port group   dir   beat content
//  s_*          in    tdata: data_bit; tuser: mode, first
//  m_*          out   tdata: code_bit; tlast: final parity bit
//  cfg_*        in    code_select write, no read-back
//
//  one beat per clock in both directions while the output is not stalled;
//  each beat passes through the selection stage, then the output register
//  the division register updates in the cycle a message beat is taken; a
//  parity read picks its bit through a two-level registered select
//  reset clears the remainder, the parity counter and code_select
//  a stalled output holds its beat; the selection stage keeps taking input
//  until it is full too
module bch_serial_encoder
    import bchse_pkg::*;
#(
    parameter int REM_BITS = REM_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [0] data_bit, [7:1] zero
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] mode, [1] first
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [0] code_bit, [7:1] zero
    output logic                 m_tlast,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_data
);

    localparam logic MODE_MSG    = 1'b0;
    localparam logic MODE_PARITY = 1'b1;

    code_sel_t            code_select_reg;
    logic [CNT_W-1:0]     pc_reg;
    logic [CNT_W-1:0]     pc_next;
    logic [REM_BITS-1:0]  rem;
    logic [MAX_DEG-1:0]   rem_pad;
    logic [CNT_W-1:0]     deg;
    logic                 code_ok;
    logic                 tap;
    logic                 s_acc;
    logic                 in_mode;
    logic                 in_bit;
    logic                 in_first;
    logic                 rd_ok;
    logic [CNT_W-1:0]     rd_idx;
    cell_ctl_t            ctl;

    logic                 en_out;
    logic                 s1_valid_reg;
    logic                 s1_is_rd_reg;
    logic                 s1_echo_reg;
    logic                 s1_last_reg;
    logic [GRP_W-1:0]     s1_grp_reg;
    logic [NUM_GRP-1:0]   s1_cand_reg;
    logic [NUM_GRP-1:0]   s1_cand_next;
    logic                 m_tvalid_reg;
    logic                 code_bit_reg;
    logic                 last_reg;

    // input fields and handshake
    assign in_mode  = s_tuser[0];
    assign in_first = s_tuser[1];
    assign in_bit   = s_tdata[0];
    assign en_out   = !m_tvalid_reg || m_tready;
    assign s_tready = !s1_valid_reg || en_out;
    assign s_acc    = s_tvalid && s_tready;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_select_reg <= CODE_N192;
        end else if (cfg_wr_en) begin
            code_select_reg <= code_sel_t'(cfg_wr_data);
        end
    end

    // code length and the top tap of the division register
    assign rem_pad = MAX_DEG'(rem);
    assign deg     = code_deg(code_select_reg);
    assign code_ok = (int'(deg) <= REM_BITS);

    always_comb begin
        case (code_select_reg)
            CODE_N192: tap = rem_pad[192-1];
            CODE_N160: tap = rem_pad[160-1];
            CODE_N128: tap = rem_pad[128-1];
            CODE_S168: tap = rem_pad[168-1];
            default:   tap = 1'b0;
        endcase
    end

    // cell control for this beat
    always_comb begin
        ctl.shift = s_acc && (in_mode == MODE_MSG) && code_ok;
        ctl.clear = s_acc && (in_mode == MODE_MSG) && in_first;
        ctl.fb    = (in_first ? 1'b0 : tap) ^ in_bit;
        ctl.sel   = code_select_reg;
    end

    // row of remainder cells, each fed by its lower neighbor
    for (genvar j = 0; j < REM_BITS; j++) begin : g_cell
        logic prev;
        if (j == 0) begin : g_head
            assign prev = 1'b0;
        end else begin : g_link
            assign prev = rem[j-1];
        end
        bchse_cell #(
            .COEF   (cell_coef(j)),
            .ACTIVE (cell_active(j))
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .prev_bit (prev),
            .rem_bit  (rem[j])
        );
    end

    // parity counter
    assign rd_ok  = code_ok && (pc_reg < deg);
    assign rd_idx = deg - pc_reg - CNT_W'(1);

    always_comb begin
        pc_next = pc_reg;
        if (s_acc && (in_mode == MODE_MSG) && in_first) begin
            pc_next = '0;
        end else if (s_acc && (in_mode == MODE_PARITY) && rd_ok) begin
            pc_next = pc_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // first select level: one candidate per group of sixteen cells
    always_comb begin
        logic [GRP_LEN-1:0] grp;
        for (int k = 0; k < NUM_GRP; k++) begin
            grp = rem_pad[k*GRP_LEN +: GRP_LEN];
            s1_cand_next[k] = grp[rd_idx[GRP_W-1:0]];
        end
    end

    // selection stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (en_out) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_is_rd_reg <= (in_mode == MODE_PARITY) && rd_ok;
            s1_echo_reg  <= (in_mode == MODE_MSG) && in_bit;
            s1_last_reg  <= (in_mode == MODE_PARITY) && rd_ok &&
                            (pc_reg == deg - CNT_W'(1));
            s1_grp_reg   <= rd_idx[CNT_W-1:GRP_W];
            s1_cand_reg  <= s1_cand_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en_out) begin
            m_tvalid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out && s1_valid_reg) begin
            code_bit_reg <= s1_is_rd_reg ? s1_cand_reg[s1_grp_reg] : s1_echo_reg;
            last_reg     <= s1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(code_bit_reg);
    assign m_tlast  = last_reg;

    // a message beat with first set restarts the parity count
    a_first_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (in_mode == MODE_MSG) && in_first |=> pc_reg == '0)
        else $error("parity counter not cleared by first message beat");

    // a valid parity read advances the counter by one
    a_read_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (in_mode == MODE_PARITY) && rd_ok |=> pc_reg == $past(pc_reg) + CNT_W'(1))
        else $error("parity counter did not advance on a parity read");

    // a full selection stage is held while the output is stalled
    a_stage_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !en_out |=> s1_valid_reg)
        else $error("selection stage dropped a beat under stall");

    // message beats never carry the last flag
    a_msg_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (in_mode == MODE_MSG) |=> !s1_last_reg)
        else $error("last flag raised on a message beat");

endmodule
